[rtl/scua_pkg.sv]
// Shared types and constants for the size class unit allocator.
// No dependencies.
package scua_pkg;
   localparam int NumClasses    = 10;
   localparam int UnitsPerClass = 64;
   localparam int LargeSlots    = 16;
   localparam int ClassW = 4;
   localparam int IndexW = 6;
   localparam int LinkW  = IndexW + 1;
   localparam int MemW   = 10;
   localparam int SlotW  = 4;
   localparam int CountW = SlotW + 1;

   typedef enum logic [2:0] {
      ST_SMALL_GRANT = 3'd0,
      ST_LARGE_REUSE = 3'd1,
      ST_FRESH       = 3'd2,
      ST_EXHAUSTED   = 3'd3,
      ST_SMALL_FREED = 3'd4,
      ST_LARGE_FREED = 3'd5,
      ST_TABLE_FULL  = 3'd6
   } status_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  grant_class;
      logic [5:0]  grant_index;
      logic [31:0] grant_addr;
      logic [31:0] grant_bytes;
   } result_type;

   function automatic logic [5:0] bit_length(input logic [30:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 31; i++) if (v[i]) n = 6'(i + 1);
      return n;
   endfunction
endpackage

[rtl/scua_large_table.sv]
// Sorted table of free large units with a one-entry-per-cycle sweep.
// Depends on scua_pkg.
module scua_large_table import scua_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        is_release,
   input  logic [31:0] key,
   input  logic [31:0] addr,
   output logic        done,
   output result_type  result
);
   typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_SHIFT_DN, S_SHIFT_UP, S_DONE} state_type;
   state_type state_ff;
   logic [31:0] sizes_ff [LargeSlots];
   logic [31:0] addrs_ff [LargeSlots];
   logic [CountW-1:0] count_ff, pos_ff;
   logic [31:0] key_ff, addr_ff;
   logic rel_ff;
   result_type res_ff;
   logic [SlotW-1:0] pi, last;
   logic [31:0] cur;
   assign pi = pos_ff[SlotW-1:0];
   assign last = SlotW'(count_ff - 1'b1);
   assign cur = sizes_ff[pi];
   assign done = (state_ff == S_DONE);
   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (start) begin
               key_ff <= key; addr_ff <= addr; rel_ff <= is_release;
               pos_ff <= '0; res_ff <= '0; state_ff <= S_CHECK;
            end
            S_CHECK: begin
               if (rel_ff) begin
                  if (count_ff >= CountW'(LargeSlots)) begin
                     res_ff.status <= ST_TABLE_FULL; state_ff <= S_DONE;
                  end else begin
                     pos_ff <= count_ff; state_ff <= S_SHIFT_UP;
                  end
               end else if (count_ff != '0 && sizes_ff[last] > key_ff) state_ff <= S_SCAN;
               else begin
                  res_ff.status <= ST_FRESH;
                  res_ff.grant_bytes <= 32'd1 << bit_length(key_ff[30:0]);
                  state_ff <= S_DONE;
               end
            end
            S_SCAN: if (cur >= key_ff) begin
               res_ff.status <= ST_LARGE_REUSE;
               res_ff.grant_addr <= addrs_ff[pi];
               res_ff.grant_bytes <= cur;
               state_ff <= S_SHIFT_DN;
            end else pos_ff <= pos_ff + 1'b1;
            S_SHIFT_DN: if (pos_ff + 1'b1 < count_ff) begin
               sizes_ff[pi] <= sizes_ff[SlotW'(pi + 1'b1)];
               addrs_ff[pi] <= addrs_ff[SlotW'(pi + 1'b1)];
               pos_ff <= pos_ff + 1'b1;
            end else begin
               count_ff <= count_ff - 1'b1; state_ff <= S_DONE;
            end
            S_SHIFT_UP: if (pos_ff != '0 && !(sizes_ff[SlotW'(pi - 1'b1)] < key_ff)) begin
               sizes_ff[pi] <= sizes_ff[SlotW'(pi - 1'b1)];
               addrs_ff[pi] <= addrs_ff[SlotW'(pi - 1'b1)];
               pos_ff <= pos_ff - 1'b1;
            end else begin
               sizes_ff[pi] <= key_ff; addrs_ff[pi] <= addr_ff;
               count_ff <= count_ff + 1'b1;
               res_ff.status <= ST_LARGE_FREED; state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/scua_class_lists.sv]
// Free lists of the small classes: link memory, heads and a reset sweep.
// Depends on scua_pkg.
module scua_class_lists import scua_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              is_release,
   input  logic [ClassW-1:0] cls,
   input  logic [IndexW-1:0] idx,
   output logic              busy_init,
   output logic              done,
   output result_type        result
);
   typedef enum logic [2:0] {S_INIT, S_IDLE, S_READ, S_WAIT, S_DONE} state_type;
   state_type state_ff;
   logic [LinkW-1:0] mem [NumClasses*UnitsPerClass];
   logic [LinkW-1:0] head_ff [NumClasses];
   logic [LinkW-1:0] rd_ff;
   logic [MemW-1:0] sweep_ff;
   logic [ClassW-1:0] cls_ff;
   logic [LinkW-1:0] h;
   result_type res_ff;
   assign h = head_ff[cls_ff];
   assign busy_init = (state_ff == S_INIT);
   assign done = (state_ff == S_DONE);
   assign result = res_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_INIT)
         mem[sweep_ff] <= LinkW'(sweep_ff[IndexW-1:0]) + 1'b1;
      else if (state_ff == S_IDLE && start && is_release
               && cls < ClassW'(NumClasses))
         mem[MemW'(cls) * MemW'(UnitsPerClass) + MemW'(idx)] <= head_ff[cls];
      rd_ff <= mem[MemW'(cls_ff) * MemW'(UnitsPerClass) + MemW'(h[IndexW-1:0])];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         sweep_ff <= '0;
         for (int c = 0; c < NumClasses; c++) head_ff[c] <= '0;
      end else begin
         unique case (state_ff)
            S_INIT: begin
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff == MemW'(NumClasses*UnitsPerClass - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (start) begin
               cls_ff <= cls;
               if (is_release) begin
                  if (cls < ClassW'(NumClasses)) head_ff[cls] <= LinkW'(idx);
                  res_ff <= '{status: ST_SMALL_FREED, default: '0};
                  state_ff <= S_DONE;
               end else begin
                  res_ff <= '0;
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               res_ff.grant_class <= cls_ff;
               res_ff.grant_bytes <= 32'd4 << cls_ff;
               if (h[IndexW]) begin
                  res_ff.status <= ST_EXHAUSTED; state_ff <= S_DONE;
               end else begin
                  res_ff.status <= ST_SMALL_GRANT;
                  res_ff.grant_index <= h[IndexW-1:0];
                  state_ff <= S_WAIT;
               end
            end
            S_WAIT: begin
               head_ff[cls_ff] <= rd_ff; state_ff <= S_DONE;
            end
            S_DONE: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

[rtl/size_class_unit_allocator.sv]
// Top level of the size class unit allocator: request decode, class pick, result register.
// Depends on scua_pkg, scua_class_lists, scua_large_table.
//  channel | dir | ports      | tdata fields (low first)
//  req     | in  | req_t*     | mode, req_size, unit_is_small, unit_class, unit_index,
//          |     |            | large_addr, large_bytes
//  rsp     | out | rsp_t*     | status, grant_class, grant_index, grant_addr, grant_bytes
// A small release updates the link memory and head directly; a small allocate reads the
// head, then its link entry. Large requests scan and shift the table one entry per cycle.
// After reset all NumClasses*UnitsPerClass (640) link entries are swept before req_tready
// rises. A stalled result holds req_tready low until it is taken.
module size_class_unit_allocator import scua_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata, // mode, req_size, unit_is_small, unit_class,
                                   // unit_index, large_addr, large_bytes, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata  // status, grant_class, grant_index, grant_addr,
                                   // grant_bytes, pad
);
   logic mode, unit_small;
   logic [30:0] size;
   logic [3:0] ucls;
   logic [5:0] uidx;
   logic [31:0] laddr, lbytes;
   assign mode = req_tdata[0];
   assign size = req_tdata[31:1];
   assign unit_small = req_tdata[32];
   assign ucls = req_tdata[36:33];
   assign uidx = req_tdata[42:37];
   assign laddr = req_tdata[74:43];
   assign lbytes = req_tdata[106:75];

   logic busy_ff, init, accept, use_small, s_done, l_done, rsp_valid_ff;
   logic [ClassW-1:0] pick;
   result_type s_res, l_res, rsp_ff;
   assign req_tready = !busy_ff && !rsp_valid_ff && !init;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      pick = ClassW'(NumClasses - 1);
      for (int c = NumClasses - 1; c >= 0; c--)
         if ({1'b0, size} <= (32'd4 << c)) pick = ClassW'(c);
   end
   assign use_small = mode ? unit_small : ({1'b0, size} <= (32'd1 << (NumClasses + 1)));

   scua_class_lists u_lists (
      .clock, .reset,
      .start(accept && use_small), .is_release(mode),
      .cls(mode ? ucls : pick), .idx(uidx),
      .busy_init(init), .done(s_done), .result(s_res));

   scua_large_table u_table (
      .clock, .reset,
      .start(accept && !use_small), .is_release(mode),
      .key(mode ? lbytes : {1'b0, size}), .addr(laddr),
      .done(l_done), .result(l_res));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) busy_ff <= 1'b1;
         if (s_done || l_done) begin
            busy_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
            rsp_ff <= s_done ? s_res : l_res;
         end else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {3'b0, rsp_ff.grant_bytes, rsp_ff.grant_addr, rsp_ff.grant_index,
                       rsp_ff.grant_class, rsp_ff.status};

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_tready) else $error("request taken while busy");
   a_single_done: assert property (@(posedge clock) disable iff (reset)
      !(s_done && l_done)) else $error("two units finished together");
   a_done_when_busy: assert property (@(posedge clock) disable iff (reset)
      (s_done || l_done) |-> busy_ff) else $error("unit finished while idle");
endmodule
